### src/fpla_pkg.sv
// ----------------------------------------------------------------------------
// fpla_pkg
// Shared widths, request codes, configuration register indexes and the
// link memory access type for the free page list allocator.
// ----------------------------------------------------------------------------
package fpla_pkg;

  // Field widths of the page index and of the page count.
  localparam int PAGE_W  = 10;
  localparam int COUNT_W = 11;

  // Request codes.
  localparam logic [1:0] REQ_BUILD = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIRST_FREE = 1'b0;
  localparam logic CFG_TOTAL      = 1'b1;

  // One access to the link memory: a read when we is low, a write otherwise.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [PAGE_W-1:0] addr;
    logic [PAGE_W-1:0] wdata;
  } link_req_t;

endpackage

### src/fpla_link_ram.sv
// ----------------------------------------------------------------------------
// fpla_link_ram
// Single-port synchronous memory that holds the successor link of every
// page. Read data is registered and appears in the cycle after the access.
// ----------------------------------------------------------------------------
module fpla_link_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  fpla_pkg::link_req_t       req,
  output logic [fpla_pkg::PAGE_W-1:0] rdata
);
  import fpla_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [PAGE_W-1:0] mem [DEPTH];

  // One access per cycle, either a write or a registered read.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr[AW-1:0]] <= req.wdata;
      end else begin
        rdata <= mem[req.addr[AW-1:0]];
      end
    end
  end

endmodule

### src/free_page_list_allocator.sv
// ----------------------------------------------------------------------------
// free_page_list_allocator
// Page allocator that keeps free pages in a singly linked list held in a
// link memory, with the list head and the free count in registers.
// ----------------------------------------------------------------------------
// Usage: a request transfers at a rising edge where start is high and busy
// is low. req_type selects build (0), allocate (1) or free (2); page_in is
// the page to free. Exactly one result follows each request: done is high
// for one cycle with page_out, status and free_count valid. The receiver
// cannot stall; the result must be taken in that cycle.
// Timing: free, an unused code, an empty allocate and a build with nothing
// to chain finish at once, with done in the cycle after the transfer. An
// allocate reads the head page's link at the transfer; in ST_ALLOC it takes
// the successor from the single memory port and clears the popped link.
// A build writes one link per cycle in ST_BUILD, from the start page to
// the last page below the limit; a first free page of 0 starts at page 1.
// Configuration: first_free_page (index 0) and total_pages (index 1) are
// written through cfg_valid/cfg_ready, which is always ready. Writes must be
// made only while the block is idle; the block itself does not enforce this.
// Reset: the list is empty (head 0, count 0); the link memory is not
// cleared, so a build must come before the first allocate.
// ----------------------------------------------------------------------------
module free_page_list_allocator #(
  parameter int NUM_PAGES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [fpla_pkg::PAGE_W-1:0]  page_in,
  output logic                         done,
  output logic [fpla_pkg::PAGE_W-1:0]  page_out,
  output logic                         status,
  output logic [fpla_pkg::COUNT_W-1:0] free_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [fpla_pkg::COUNT_W-1:0] cfg_data
);
  import fpla_pkg::*;

  localparam int SPAN  = 2 ** PAGE_W;
  localparam int DEPTH = (NUM_PAGES < SPAN) ? NUM_PAGES : SPAN;
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;

  logic [1:0]         state, state_next;
  logic [PAGE_W-1:0]  head_page, head_page_next;
  logic [COUNT_W-1:0] free_total, free_total_next;
  logic [PAGE_W-1:0]  ptr, ptr_next;
  logic               done_next;
  logic [PAGE_W-1:0]  page_out_next;
  logic               status_next;
  logic [PAGE_W-1:0]  first_free_page;
  logic [COUNT_W-1:0] total_pages;

  logic [COUNT_W-1:0] lim;
  logic [PAGE_W-1:0]  start_pg;
  logic [COUNT_W-1:0] start_ext;
  logic [COUNT_W-1:0] ptr_inc;
  logic               accept;
  link_req_t          link_req;
  logic [PAGE_W-1:0]  link_rdata;

  fpla_link_ram #(.DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rdata)
  );

  // Configuration registers; the channel never holds a transfer off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_page <= PAGE_W'(1);
      total_pages     <= COUNT_W'(SPAN);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIRST_FREE) begin
        first_free_page <= cfg_data[PAGE_W-1:0];
      end else begin
        total_pages <= cfg_data;
      end
    end
  end

  // Page limit and effective start of the chain; page 0 is the null marker.
  assign lim       = (total_pages < DEPTH_C) ? total_pages : DEPTH_C;
  assign start_pg  = (first_free_page == '0) ? PAGE_W'(1) : first_free_page;
  assign start_ext = {1'b0, start_pg};
  assign ptr_inc   = {1'b0, ptr} + COUNT_W'(1);
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // Request sequencing and link memory access.
  always_comb begin
    state_next      = state;
    head_page_next  = head_page;
    free_total_next = free_total;
    ptr_next        = ptr;
    done_next       = 1'b0;
    page_out_next   = page_out;
    status_next     = status;
    link_req        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          page_out_next = '0;
          status_next   = 1'b0;
          case (req_type)
            REQ_BUILD: begin
              if (start_ext >= lim) begin
                head_page_next  = '0;
                free_total_next = '0;
                done_next       = 1'b1;
              end else begin
                ptr_next   = start_pg;
                state_next = ST_BUILD;
              end
            end
            REQ_ALLOC: begin
              if (free_total == '0 || head_page == '0) begin
                status_next = 1'b1;
                done_next   = 1'b1;
              end else begin
                link_req.en   = 1'b1;
                link_req.addr = head_page;
                state_next    = ST_ALLOC;
              end
            end
            REQ_FREE: begin
              if (page_in != '0 && {1'b0, page_in} < lim) begin
                link_req.en    = 1'b1;
                link_req.we    = 1'b1;
                link_req.addr  = page_in;
                link_req.wdata = head_page;
                head_page_next = page_in;
                if (free_total < lim) begin
                  free_total_next = free_total + COUNT_W'(1);
                end
              end
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        // The successor of the old head is back; clear the popped link.
        link_req.en     = 1'b1;
        link_req.we     = 1'b1;
        link_req.addr   = head_page;
        page_out_next   = head_page;
        head_page_next  = link_rdata;
        free_total_next = free_total - COUNT_W'(1);
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_BUILD: begin
        // Chain one page per cycle; the last page links to null.
        link_req.en   = 1'b1;
        link_req.we   = 1'b1;
        link_req.addr = ptr;
        if (ptr_inc < lim) begin
          link_req.wdata = ptr_inc[PAGE_W-1:0];
          ptr_next       = ptr_inc[PAGE_W-1:0];
        end else begin
          head_page_next  = start_pg;
          free_total_next = lim - start_ext;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_page  <= '0;
      free_total <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head_page  <= head_page_next;
      free_total <= free_total_next;
      done       <= done_next;
    end
  end

  // Result payload and build pointer.
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    page_out <= page_out_next;
    status   <= status_next;
  end

  assign free_count = free_total;

  // A result only follows an accepted request or a busy cycle.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || busy))
    else $error("result without a request in flight");

  // The allocate completion cycle always follows a link read.
  a_alloc_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC) |-> $past(link_req.en && !link_req.we))
    else $error("allocate completion without a link read");

  // An empty allocate never hands out a page.
  a_empty_page: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (page_out == '0))
    else $error("empty allocate returned a page");

  // An allocate returns from ST_ALLOC to the idle state with done high.
  a_alloc_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC) |=> (state == ST_IDLE && done))
    else $error("allocate did not finish after one cycle");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the free page list allocator. A short table of
// directed requests and register writes covers the empty list, the
// extremes of the page range, bad and double frees and the unused request
// code. Random phases follow, each with its own register setting and a
// mix of allocates, frees of held pages and noise. Every result is
// compared with its table entry or a local model of the list.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpla_pkg::*;

  localparam int PAGE_SLOTS   = 1024;
  localparam int STALL_LIMIT  = 6000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 119;
  localparam int MAX_REPORTS  = 10;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One result of the allocator, field by field.
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic               status;
    logic [COUNT_W-1:0] count;
  } page_grant_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  // One row of the directed table: a request or a register write.
  typedef struct {
    row_kind_t          kind;
    logic [1:0]         req;
    logic [PAGE_W-1:0]  page;
    logic               reg_index;
    logic [COUNT_W-1:0] reg_value;
    bit                 fixed;
    page_grant_t        want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 29;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_BUILD;
  logic [PAGE_W-1:0]  page_in = '0;
  logic               done;
  logic [PAGE_W-1:0]  page_out;
  logic               status;
  logic [COUNT_W-1:0] free_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_FIRST_FREE;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Local copy of the allocator state and its registers.
  logic [PAGE_W-1:0]  first_free_reg = PAGE_W'(1);
  logic [COUNT_W-1:0] total_pages_reg = COUNT_W'(1024);
  logic [PAGE_W-1:0]  list_head = '0;
  logic [COUNT_W-1:0] free_total = '0;
  logic [PAGE_W-1:0]  link_mem [PAGE_SLOTS];

  page_grant_t        pending_results [$];
  logic [PAGE_W-1:0]  held_pages [$];
  int                 error_count = 0;
  int                 stall_cycles = 0;
  bit                 steady = 1'b0;
  stim_row_t          directed [DIRECTED_ROWS];

  free_page_list_allocator #(
    .NUM_PAGES(PAGE_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .page_in   (page_in),
    .done      (done),
    .page_out  (page_out),
    .status    (status),
    .free_count(free_count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Apply one request to the local list and return the result it gives.
  function automatic page_grant_t predict_page_grant(input logic [1:0] req,
                                                     input logic [PAGE_W-1:0] page);
    page_grant_t res;
    int          lim;
    int          first;
    lim   = (int'(total_pages_reg) > PAGE_SLOTS) ? PAGE_SLOTS : int'(total_pages_reg);
    first = (first_free_reg == '0) ? 1 : int'(first_free_reg);
    res   = '0;
    case (req)
      REQ_BUILD: begin
        if (first >= lim) begin
          list_head  = '0;
          free_total = '0;
        end else begin
          for (int i = first; i + 1 < lim; i++) link_mem[i] = PAGE_W'(i + 1);
          link_mem[lim-1] = '0;
          list_head  = PAGE_W'(first);
          free_total = COUNT_W'(lim - first);
        end
      end
      REQ_ALLOC: begin
        if (free_total == '0 || list_head == '0) begin
          res.status = 1'b1;
        end else begin
          res.page           = list_head;
          list_head          = link_mem[res.page];
          link_mem[res.page] = '0;
          free_total         = free_total - COUNT_W'(1);
        end
      end
      REQ_FREE: begin
        // Page 0 and pages at or above the limit are dropped; double frees are not.
        if (page != '0 && int'(page) < lim) begin
          link_mem[page] = list_head;
          list_head      = page;
          if (int'(free_total) < lim) free_total = free_total + COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    res.count = free_total;
    return res;
  endfunction

  function automatic stim_row_t req_row(input logic [1:0] req, input int page);
    stim_row_t r;
    r = '{kind: ROW_REQUEST, req: req, page: PAGE_W'(page), reg_index: CFG_FIRST_FREE,
          reg_value: '0, fixed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [1:0] req, input int page,
                                          input int grant, input bit empty, input int count);
    stim_row_t r;
    r       = req_row(req, page);
    r.fixed = 1'b1;
    r.want  = '{page: PAGE_W'(grant), status: empty, count: COUNT_W'(count)};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input int value);
    stim_row_t r;
    r = '{kind: ROW_CONFIG, req: REQ_BUILD, page: '0, reg_index: idx,
          reg_value: COUNT_W'(value), fixed: 1'b0, want: '0};
    return r;
  endfunction

  // Hold requests off until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Present one request, wait for its transfer and record what it must give.
  task automatic issue_request(input logic [1:0] req, input logic [PAGE_W-1:0] page,
                               input bit fixed, input page_grant_t want);
    page_grant_t got;
    while (!steady && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= req;
    page_in  <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = predict_page_grant(req, page);
    pending_results.push_back(fixed ? want : got);
    if (req == REQ_BUILD) held_pages.delete();
    if (req == REQ_ALLOC && !got.status) held_pages.push_back(got.page);
  endtask

  // Register writes are made only with the allocator idle.
  task automatic write_config(input logic idx, input logic [COUNT_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIRST_FREE) first_free_reg = value[PAGE_W-1:0];
    else total_pages_reg = value;
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin : check_results
    page_grant_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: page %0d status %0d count %0d",
                   page_out, status, free_count);
      end else begin
        want = pending_results.pop_front();
        if (page_out !== want.page || status !== want.status || free_count !== want.count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected page %0d status %0d count %0d, got %0d %0d %0d",
                     want.page, want.status, want.count, page_out, status, free_count);
        end
      end
    end
  end

  // Stop the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int          r;
    int          pick;
    int          first_sel;
    int          total_sel;
    logic [PAGE_W-1:0] pg;

    foreach (link_mem[i]) link_mem[i] = '0;

    // Directed requests: empty list after reset, extremes, bad and double
    // frees, the unused code, a start of zero and a list with nothing to build.
    directed = '{
      known_row(REQ_ALLOC, 0, 0, 1'b1, 0),
      known_row(REQ_UNUSED, 1023, 0, 1'b0, 0),
      known_row(REQ_FREE, 0, 0, 1'b0, 0),
      known_row(REQ_FREE, 7, 0, 1'b0, 1),
      known_row(REQ_ALLOC, 0, 7, 1'b0, 0),
      known_row(REQ_ALLOC, 0, 0, 1'b1, 0),
      known_row(REQ_BUILD, 0, 0, 1'b0, 1023),
      known_row(REQ_ALLOC, 0, 1, 1'b0, 1022),
      req_row(REQ_FREE, 1023),
      req_row(REQ_FREE, 1023),
      req_row(REQ_FREE, 1),
      req_row(REQ_ALLOC, 0),
      cfg_row(CFG_FIRST_FREE, 0),
      cfg_row(CFG_TOTAL, 4),
      known_row(REQ_BUILD, 0, 0, 1'b0, 3),
      known_row(REQ_ALLOC, 0, 1, 1'b0, 2),
      known_row(REQ_FREE, 4, 0, 1'b0, 2),
      req_row(REQ_FREE, 3),
      req_row(REQ_ALLOC, 0),
      cfg_row(CFG_FIRST_FREE, 1023),
      cfg_row(CFG_TOTAL, 2),
      known_row(REQ_BUILD, 0, 0, 1'b0, 0),
      known_row(REQ_ALLOC, 0, 0, 1'b1, 0),
      known_row(REQ_FREE, 1, 0, 1'b0, 1),
      known_row(REQ_ALLOC, 0, 1, 1'b0, 0),
      cfg_row(CFG_TOTAL, 1024),
      known_row(REQ_BUILD, 0, 0, 1'b0, 1),
      known_row(REQ_ALLOC, 0, 1023, 1'b0, 0),
      known_row(REQ_ALLOC, 0, 0, 1'b1, 0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CONFIG) begin
        write_config(directed[i].reg_index, directed[i].reg_value);
      end else begin
        issue_request(directed[i].req, directed[i].page, directed[i].fixed, directed[i].want);
      end
    end

    // Random phases, each with its own setting and a fresh list.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin first_sel = 1; total_sel = 1024; end
        1: begin first_sel = 0; total_sel = 8; end
        7: begin first_sel = 1023; total_sel = 1024; end
        8: begin first_sel = 1; total_sel = 2; end
        9: begin first_sel = $urandom_range(1, 3); total_sel = 1024; end
        default: begin
          first_sel = $urandom_range(1, 20);
          total_sel = $urandom_range(2, 64);
        end
      endcase
      if ($urandom_range(1)) begin
        write_config(CFG_TOTAL, COUNT_W'(total_sel));
        write_config(CFG_FIRST_FREE, COUNT_W'(first_sel));
      end else begin
        write_config(CFG_FIRST_FREE, COUNT_W'(first_sel));
        write_config(CFG_TOTAL, COUNT_W'(total_sel));
      end
      steady = (phase == 4 || phase == 5);
      issue_request(REQ_BUILD, PAGE_W'($urandom_range(1023)), 1'b0, '0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(59) == 0) drain_results();
        r  = $urandom_range(99);
        pg = PAGE_W'($urandom_range(1023));
        if (r < 45) begin
          issue_request(REQ_ALLOC, pg, 1'b0, '0);
        end else if (r < 80) begin
          // Mostly give back a page that was handed out.
          if (held_pages.size() != 0) begin
            pick = $urandom_range(held_pages.size() - 1);
            pg   = held_pages[pick];
            held_pages.delete(pick);
          end
          issue_request(REQ_FREE, pg, 1'b0, '0);
        end else if (r < 91) begin
          issue_request(REQ_FREE, pg, 1'b0, '0);
        end else if (r < 97) begin
          issue_request(REQ_UNUSED, pg, 1'b0, '0);
        end else begin
          issue_request(REQ_BUILD, pg, 1'b0, '0);
        end
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
